### hdl/i2c_master_bit_sequencer_unit_defines.svh
// Assertion macros for the I2C master bit sequencer.
// Used by the top level; expects clk_i and rst_ni in the scope of use.
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CMBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define I2CMBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define I2CMBS_ASSERT(lbl, prop, msg)
`define I2CMBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/i2cmbs_pkg.sv
// Shared types for the I2C master bit sequencer.
// No dependencies.
package i2cmbs_pkg;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_STOP     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_READ     = 3'd3,
    MODE_SEND_ACK = 3'd4,
    MODE_RECV_ACK = 3'd5
  } mode_e;

  localparam int unsigned StepW = 2;
  localparam int unsigned BitW  = 3;
  localparam logic [BitW-1:0] LastBit = 3'd7;

  // One pin phase plus how the sequencer advances afterwards
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             sample;
    logic             last;
    logic [7:0]       rx_byte;
    logic             rx_ack;
    logic [StepW-1:0] step_nxt;
    logic             bit_inc;
  } phase_t;

  function automatic logic mode_known(input logic [2:0] code);
    return code <= MODE_RECV_ACK;
  endfunction

endpackage

### hdl/i2cmbs_phase_gen.sv
// Phase decoder: turns command, step and bit position into one pin phase.
// Depends on i2cmbs_pkg.
module i2cmbs_phase_gen (
  input  i2cmbs_pkg::mode_e                mode_i,
  input  logic [i2cmbs_pkg::StepW-1:0]     step_i,
  input  logic [i2cmbs_pkg::BitW-1:0]      bit_i,
  input  logic [7:0]                       tx_byte_i,
  input  logic                             ack_out_i,
  input  logic [7:0]                       line_bits_i,
  input  logic                             line_ack_i,
  input  logic                             scl_cur_i,
  input  logic                             sda_cur_i,
  output i2cmbs_pkg::phase_t               phase_o
);

  logic drv_scl, scl_val, drv_sda, sda_val;
  logic sample, last, bit_inc, rx_ack;
  logic [7:0] rx_byte;
  logic [i2cmbs_pkg::StepW-1:0] step_nxt;
  logic last_bit;

  assign last_bit = (bit_i == i2cmbs_pkg::LastBit);

  always_comb begin
    drv_scl  = 1'b0;
    scl_val  = 1'b0;
    drv_sda  = 1'b0;
    sda_val  = 1'b0;
    sample   = 1'b0;
    last     = 1'b0;
    bit_inc  = 1'b0;
    rx_ack   = 1'b0;
    rx_byte  = 8'd0;
    step_nxt = step_i + 2'd1;
    unique case (mode_i)
      i2cmbs_pkg::MODE_START: begin
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = 1'b1; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          2'd2: begin drv_sda = 1'b1; sda_val = 1'b0; end
          default: begin drv_scl = 1'b1; scl_val = 1'b0; last = 1'b1; end
        endcase
      end
      i2cmbs_pkg::MODE_STOP: begin
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = 1'b0; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          default: begin drv_sda = 1'b1; sda_val = 1'b1; last = 1'b1; end
        endcase
      end
      i2cmbs_pkg::MODE_WRITE: begin
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = tx_byte_i[i2cmbs_pkg::LastBit - bit_i]; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          default: begin
            drv_scl  = 1'b1;
            scl_val  = 1'b0;
            step_nxt = 2'd0;
            bit_inc  = 1'b1;
            last     = last_bit;
          end
        endcase
      end
      i2cmbs_pkg::MODE_READ: begin
        // release SDA once, then loop over clock high, sample, clock low
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = 1'b1; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          2'd2: sample = 1'b1;
          default: begin
            drv_scl  = 1'b1;
            scl_val  = 1'b0;
            step_nxt = 2'd1;
            bit_inc  = 1'b1;
            last     = last_bit;
            rx_byte  = last_bit ? line_bits_i : 8'd0;
          end
        endcase
      end
      i2cmbs_pkg::MODE_SEND_ACK: begin
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = ack_out_i; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          default: begin drv_scl = 1'b1; scl_val = 1'b0; last = 1'b1; end
        endcase
      end
      i2cmbs_pkg::MODE_RECV_ACK: begin
        unique case (step_i)
          2'd0: begin drv_sda = 1'b1; sda_val = 1'b1; end
          2'd1: begin drv_scl = 1'b1; scl_val = 1'b1; end
          2'd2: sample = 1'b1;
          default: begin
            drv_scl = 1'b1;
            scl_val = 1'b0;
            last    = 1'b1;
            rx_ack  = line_ack_i;
          end
        endcase
      end
      default: last = 1'b1;
    endcase
  end

  always_comb begin
    phase_o.scl      = drv_scl ? scl_val : scl_cur_i;
    phase_o.sda      = drv_sda ? sda_val : sda_cur_i;
    phase_o.sample   = sample;
    phase_o.last     = last;
    phase_o.rx_byte  = rx_byte;
    phase_o.rx_ack   = rx_ack;
    phase_o.step_nxt = step_nxt;
    phase_o.bit_inc  = bit_inc;
  end

endmodule

### hdl/i2c_master_bit_sequencer_unit.sv
// The first phase of a command passes through the command register into the output register.
// Throughput: one phase per cycle while the output is not stalled; a command holds the input for
// its 3 to 25 phases, paced by the step and bit counters of the command register.
// The next command is taken in the cycle in which the last phase loads the output register.
// Reset (rst_ni, asynchronous, active low): idle, no result pending, SCL and SDA released high.
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2c_master_bit_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       ack_out_i,
  input  logic [7:0] line_bits_i,
  input  logic       line_ack_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_o,
  output logic       sda_o,
  output logic       sample_point_o,
  output logic       last_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_ack_o
);

  logic                             busy_q, busy_d;
  logic [i2cmbs_pkg::StepW-1:0]     step_q, step_d;
  logic [i2cmbs_pkg::BitW-1:0]      bit_q, bit_d;
  i2cmbs_pkg::mode_e                mode_q;
  logic [7:0]                       tx_q, lbits_q;
  logic                             ack_q, lack_q;
  logic                             scl_q, scl_d, sda_q, sda_d;
  logic                             out_valid_q, out_valid_d;
  i2cmbs_pkg::phase_t               phase;
  logic                             issue, take, load;

  i2cmbs_phase_gen u_phase_gen (
    .mode_i      (mode_q),
    .step_i      (step_q),
    .bit_i       (bit_q),
    .tx_byte_i   (tx_q),
    .ack_out_i   (ack_q),
    .line_bits_i (lbits_q),
    .line_ack_i  (lack_q),
    .scl_cur_i   (scl_q),
    .sda_cur_i   (sda_q),
    .phase_o     (phase)
  );

  // a phase moves into the output register when that register is free or draining
  assign issue      = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !(issue && phase.last);
  assign take       = in_valid_i && !in_stall_o;
  // drop unknown command codes on transfer
  assign load       = take && i2cmbs_pkg::mode_known(mode_i);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    bit_d  = bit_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    if (issue) begin
      scl_d  = phase.scl;
      sda_d  = phase.sda;
      step_d = phase.step_nxt;
      bit_d  = phase.bit_inc ? bit_q + 3'd1 : bit_q;
      if (phase.last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
      bit_d  = '0;
    end
    if (issue) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      bit_q       <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      bit_q       <= bit_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q  <= i2cmbs_pkg::mode_e'(mode_i);
      tx_q    <= tx_byte_i;
      ack_q   <= ack_out_i;
      lbits_q <= line_bits_i;
      lack_q  <= line_ack_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      scl_o          <= phase.scl;
      sda_o          <= phase.sda;
      sample_point_o <= phase.sample;
      last_o         <= phase.last;
      rx_byte_o      <= phase.rx_byte;
      rx_ack_o       <= phase.rx_ack;
    end
  end

  assign out_valid_o = out_valid_q;

  `I2CMBS_ASSERT(a_sample_with_scl_high, (out_valid_o && sample_point_o) |-> scl_o, "sample phase with SCL low")
  `I2CMBS_ASSERT(a_take_only_on_last, (take && busy_q) |-> (issue && phase.last), "command taken mid-sequence")
  `I2CMBS_ASSERT(a_rx_only_on_last, (out_valid_o && !last_o) |-> (rx_byte_o == 8'd0 && !rx_ack_o), "receive data outside last phase")
  `I2CMBS_ASSERT(a_lines_track_output, out_valid_o |-> (scl_o == scl_q && sda_o == sda_q), "line state differs from shown phase")
  `I2CMBS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!out_valid_q || rst_ni), "result valid during reset")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the I2C master bit sequencer: expands each command taken into its
// pin phases and checks every phase that leaves the block against them.
// Depends on i2cmbs_pkg and the i2c_master_bit_sequencer_unit top level.
module tb;

  // Codes the block must ignore
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sample;
    logic       last;
    logic [7:0] rx_byte;
    logic       rx_ack;
  } pin_phase_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [2:0] mode_i      = 3'd0;
  logic [7:0] tx_byte_i   = 8'h00;
  logic       ack_out_i   = 1'b0;
  logic [7:0] line_bits_i = 8'h00;
  logic       line_ack_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       scl_o;
  logic       sda_o;
  logic       sample_point_o;
  logic       last_o;
  logic [7:0] rx_byte_o;
  logic       rx_ack_o;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_req  = 1'b0;
  int unsigned hold_cnt  = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // Line levels as the predictor sees them
  logic       bus_scl = 1'b1;
  logic       bus_sda = 1'b1;
  pin_phase_t expected_phases[$];

  i2c_master_bit_sequencer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .tx_byte_i      (tx_byte_i),
    .ack_out_i      (ack_out_i),
    .line_bits_i    (line_bits_i),
    .line_ack_i     (line_ack_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_o          (scl_o),
    .sda_o          (sda_o),
    .sample_point_o (sample_point_o),
    .last_o         (last_o),
    .rx_byte_o      (rx_byte_o),
    .rx_ack_o       (rx_ack_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d phases outstanding", cycle_cnt,
               expected_phases.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void put_phase(input logic smp);
    pin_phase_t ph;
    ph = '{scl: bus_scl, sda: bus_sda, sample: smp, last: 1'b0,
           rx_byte: 8'h00, rx_ack: 1'b0};
    expected_phases.push_back(ph);
  endfunction

  function automatic void drive_scl(input logic v);
    bus_scl = v;
    put_phase(1'b0);
  endfunction

  function automatic void drive_sda(input logic v);
    bus_sda = v;
    put_phase(1'b0);
  endfunction

  function automatic void expand_command(input logic [2:0] mode, input logic [7:0] tx,
                                         input logic ackv, input logic [7:0] lbits,
                                         input logic lack);
    pin_phase_t tail;
    case (mode)
      i2cmbs_pkg::MODE_START: begin
        drive_sda(1'b1);
        drive_scl(1'b1);
        drive_sda(1'b0);
        drive_scl(1'b0);
      end
      i2cmbs_pkg::MODE_STOP: begin
        drive_sda(1'b0);
        drive_scl(1'b1);
        drive_sda(1'b1);
      end
      i2cmbs_pkg::MODE_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          drive_sda(tx[i]);
          drive_scl(1'b1);
          drive_scl(1'b0);
        end
      end
      i2cmbs_pkg::MODE_READ: begin
        drive_sda(1'b1);
        for (int i = 0; i < 8; i++) begin
          drive_scl(1'b1);
          put_phase(1'b1);
          drive_scl(1'b0);
        end
      end
      i2cmbs_pkg::MODE_SEND_ACK: begin
        drive_sda(ackv);
        drive_scl(1'b1);
        drive_scl(1'b0);
      end
      i2cmbs_pkg::MODE_RECV_ACK: begin
        drive_sda(1'b1);
        drive_scl(1'b1);
        put_phase(1'b1);
        drive_scl(1'b0);
      end
      default: return;
    endcase
    // mark the closing phase and attach what was read
    tail = expected_phases.pop_back();
    tail.last = 1'b1;
    if (mode == i2cmbs_pkg::MODE_READ) tail.rx_byte = lbits;
    if (mode == i2cmbs_pkg::MODE_RECV_ACK) tail.rx_ack = lack;
    expected_phases.push_back(tail);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input pin_phase_t got,
                                 input pin_phase_t want);
    err_cnt++;
    $write("[%0t] %s: got scl=%b sda=%b smp=%b last=%b rx=%h ack=%b,",
           $realtime, what, got.scl, got.sda, got.sample, got.last, got.rx_byte,
           got.rx_ack);
    $display(" want scl=%b sda=%b smp=%b last=%b rx=%h ack=%b",
             want.scl, want.sda, want.sample, want.last, want.rx_byte, want.rx_ack);
  endtask

  always @(posedge clk_i) begin : phase_check
    pin_phase_t got;
    pin_phase_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{scl: scl_o, sda: sda_o, sample: sample_point_o, last: last_o,
              rx_byte: rx_byte_o, rx_ack: rx_ack_o};
      if (expected_phases.size() == 0) begin
        report_mismatch("unexpected phase", got, got);
      end else begin
        want = expected_phases.pop_front();
        if (got !== want) report_mismatch("phase mismatch", got, want);
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_OFF_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_command(input logic [2:0] mode, input logic [7:0] tx, input logic ackv,
                              input logic [7:0] lbits, input logic lack);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    tx_byte_i   <= tx;
    ack_out_i   <= ackv;
    line_bits_i <= lbits;
    line_ack_i  <= lack;
    do @(posedge clk_i); while (in_stall_o);
    expand_command(mode, tx, ackv, lbits, lack);
  endtask

  // random content in every field, relevant or not
  task automatic send_rand(input logic [2:0] mode);
    send_command(mode, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_commands;
    gap_pct   = 0;
    stall_pct = 0;
    send_command(i2cmbs_pkg::MODE_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_START, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(i2cmbs_pkg::MODE_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1);
    send_command(i2cmbs_pkg::MODE_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0);
    send_command(i2cmbs_pkg::MODE_RECV_ACK, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_RECV_ACK, 8'h00, 1'b0, 8'h00, 1'b1);
    send_command(i2cmbs_pkg::MODE_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
    send_command(i2cmbs_pkg::MODE_SEND_ACK, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_command(i2cmbs_pkg::MODE_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_command(i2cmbs_pkg::MODE_SEND_ACK, 8'hFF, 1'b1, 8'h00, 1'b1);
    send_command(i2cmbs_pkg::MODE_READ, 8'h3C, 1'b0, 8'h5A, 1'b1);
    // repeated start with SCL low
    send_command(i2cmbs_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1);
  endtask

  // reserved codes must leave no phase and no change on the lines
  task automatic test_ignored_modes;
    gap_pct   = 0;
    stall_pct = 0;
    send_command(MODE_RSVD_6, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(MODE_RSVD_7, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(MODE_RSVD_7, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(i2cmbs_pkg::MODE_SEND_ACK, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(MODE_RSVD_6, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(i2cmbs_pkg::MODE_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  // hold the receiver off while commands keep coming so the input backs up
  task automatic test_input_backpressure;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    send_rand(i2cmbs_pkg::MODE_START);
    send_rand(i2cmbs_pkg::MODE_WRITE);
    send_rand(i2cmbs_pkg::MODE_RECV_ACK);
    send_rand(i2cmbs_pkg::MODE_READ);
    send_rand(i2cmbs_pkg::MODE_SEND_ACK);
    send_rand(i2cmbs_pkg::MODE_READ);
    send_rand(i2cmbs_pkg::MODE_SEND_ACK);
    send_rand(i2cmbs_pkg::MODE_STOP);
  endtask

  // mostly well-formed transactions, some stray or reserved commands between
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned n_cmds);
    int unsigned sent;
    int unsigned n_bytes;
    logic [2:0]  m;
    bit          rd;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_cmds) begin
      if ($urandom_range(9) == 0) begin
        m = 3'($urandom_range(7));
        send_rand(m);
        if (m <= i2cmbs_pkg::MODE_RECV_ACK) sent++;
      end else begin
        rd      = 1'($urandom_range(1));
        n_bytes = $urandom_range(1, 4);
        send_rand(i2cmbs_pkg::MODE_START);
        send_rand(i2cmbs_pkg::MODE_WRITE);
        send_rand(i2cmbs_pkg::MODE_RECV_ACK);
        for (int b = 0; b < n_bytes; b++) begin
          if (rd) begin
            send_rand(i2cmbs_pkg::MODE_READ);
            send_rand(i2cmbs_pkg::MODE_SEND_ACK);
          end else begin
            send_rand(i2cmbs_pkg::MODE_WRITE);
            send_rand(i2cmbs_pkg::MODE_RECV_ACK);
          end
        end
        sent += 3 + 2 * n_bytes;
        // leave the stop out now and then for a repeated start
        if ($urandom_range(4) != 0) begin
          send_rand(i2cmbs_pkg::MODE_STOP);
          sent++;
        end
      end
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_commands();
    test_ignored_modes();
    test_input_backpressure();
    test_random_traffic(0, 0, 55);
    test_random_traffic(51, 0, 55);
    test_random_traffic(0, 51, 55);
    test_random_traffic(20, 20, 55);
    drain();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### i2c_master_bit_sequencer_unit.f
+incdir+hdl
hdl/i2cmbs_pkg.sv
hdl/i2cmbs_phase_gen.sv
hdl/i2c_master_bit_sequencer_unit.sv
dv/tb.sv
